// ===== hdl/bre_pkg.sv =====
// ----------------------------------------------------------------------------
// Bilevel byte run-length encoder: shared definitions
// Widths, code constants and the packet type that travels from the front
// part, through the queue, to the back part.
// ----------------------------------------------------------------------------
package bre_pkg;

   // Field widths.
   localparam int CODE_W = 8;
   localparam int LEN_W  = 12;

   // Marker bytes and count limits.
   localparam logic [CODE_W-1:0] MARK_ZEROS = 8'h00;
   localparam logic [CODE_W-1:0] MARK_ONES  = 8'hFF;
   localparam logic [CODE_W-1:0] COUNT_MAX  = 8'hFF;
   localparam logic [LEN_W-1:0]  LEN_MAX    = 12'hFFF;
   localparam logic [LEN_W-1:0]  HDR_LIMIT  = 12'd255;

   // Largest number of code words that one pixel byte can cause.
   localparam int MAX_CODES = 4;
   localparam int SLOT_W    = $clog2(MAX_CODES);

   // Default depth of the queue between front and back.
   localparam int QUEUE_DEPTH_DEF = 4;

   // One classified pixel byte: its code words and row information.
   typedef struct packed {
      logic [MAX_CODES-1:0][CODE_W-1:0] code;
      logic [SLOT_W-1:0]                last_idx;
      logic                             row_end;
      logic [LEN_W-1:0]                 row_length;
      logic                             overflow;
   } pkt_type;

endpackage

// ===== hdl/bre_front.sv =====
// ----------------------------------------------------------------------------
// Bilevel byte run-length encoder: front part
// Accepts pixel bytes, tracks the open run and the row's payload length,
// and pushes the code words each byte causes into the queue.
// ----------------------------------------------------------------------------
module bre_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [bre_pkg::CODE_W-1:0]      req_pixel_byte,
   input  logic                            req_row_end,
   input  logic                            q_full,
   output logic                            q_push,
   output bre_pkg::pkt_type                q_data
);
   import bre_pkg::*;

   typedef enum logic [1:0] {
      KIND_LIT   = 2'd0,
      KIND_ONES  = 2'd1,
      KIND_ZEROS = 2'd2
   } kind_type;

   kind_type                          kind_ff, kind_in;
   logic [CODE_W-1:0]                 count_ff, count_in;
   logic [LEN_W-1:0]                  pay_ff, pay_in;

   logic                              accept;
   logic                              is_zero, is_ones, is_run;
   kind_type                          byte_kind;
   logic [CODE_W-1:0]                 byte_mark;
   logic [MAX_CODES-1:0][CODE_W-1:0]  code_v;
   logic [SLOT_W:0]                   n_v;
   kind_type                          kind_v;
   logic [CODE_W-1:0]                 count_v;
   logic [LEN_W:0]                    sum_v;
   logic [LEN_W-1:0]                  len_v;

   // The queue is the only source of back-pressure.
   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   // Classify the incoming byte.
   assign is_zero   = (req_pixel_byte == MARK_ZEROS);
   assign is_ones   = (req_pixel_byte == MARK_ONES);
   assign is_run    = is_zero || is_ones;
   assign byte_kind = is_zero ? KIND_ZEROS : KIND_ONES;
   assign byte_mark = is_zero ? MARK_ZEROS : MARK_ONES;

   // Work out the code words for this byte and the next run state.
   always_comb begin
      code_v  = '0;
      n_v     = '0;
      kind_v  = kind_ff;
      count_v = count_ff;
      if (is_run) begin
         if (kind_ff == byte_kind) begin
            if (count_ff == COUNT_MAX) begin
               // A full run is closed and a new one opened with this byte.
               code_v[n_v[SLOT_W-1:0]] = byte_mark;
               n_v                     = n_v + 1'b1;
               code_v[n_v[SLOT_W-1:0]] = COUNT_MAX;
               n_v                     = n_v + 1'b1;
               count_v                 = 8'd1;
            end else begin
               count_v = count_ff + 8'd1;
            end
         end else begin
            if (kind_ff == KIND_ONES || kind_ff == KIND_ZEROS) begin
               code_v[n_v[SLOT_W-1:0]] = (kind_ff == KIND_ZEROS) ? MARK_ZEROS : MARK_ONES;
               n_v                     = n_v + 1'b1;
               code_v[n_v[SLOT_W-1:0]] = count_ff;
               n_v                     = n_v + 1'b1;
            end
            count_v = 8'd1;
         end
         kind_v = byte_kind;
      end else begin
         // Literal byte: close any open run, then pass the byte through.
         if (kind_ff == KIND_ONES || kind_ff == KIND_ZEROS) begin
            code_v[n_v[SLOT_W-1:0]] = (kind_ff == KIND_ZEROS) ? MARK_ZEROS : MARK_ONES;
            n_v                     = n_v + 1'b1;
            code_v[n_v[SLOT_W-1:0]] = count_ff;
            n_v                     = n_v + 1'b1;
         end
         code_v[n_v[SLOT_W-1:0]] = req_pixel_byte;
         n_v                     = n_v + 1'b1;
         count_v                 = '0;
         kind_v                  = KIND_LIT;
      end
      // At row end the run left open is flushed as well.
      if (req_row_end && (kind_v == KIND_ONES || kind_v == KIND_ZEROS)) begin
         code_v[n_v[SLOT_W-1:0]] = (kind_v == KIND_ZEROS) ? MARK_ZEROS : MARK_ONES;
         n_v                     = n_v + 1'b1;
         code_v[n_v[SLOT_W-1:0]] = count_v;
         n_v                     = n_v + 1'b1;
      end
   end

   // Payload length of the row so far, held at its largest value.
   assign sum_v = {1'b0, pay_ff} + (LEN_W+1)'(n_v);
   assign len_v = (sum_v > {1'b0, LEN_MAX}) ? LEN_MAX : sum_v[LEN_W-1:0];

   // Next state: a row end returns to an empty ones run.
   always_comb begin
      if (req_row_end) begin
         kind_in  = KIND_ONES;
         count_in = '0;
         pay_in   = '0;
      end else begin
         kind_in  = kind_v;
         count_in = count_v;
         pay_in   = len_v;
      end
   end

   // Queue entry; bytes that only extend a run produce none.
   assign q_push              = accept && (n_v != '0);
   assign q_data.code         = code_v;
   assign q_data.last_idx     = SLOT_W'(n_v - 1'b1);
   assign q_data.row_end      = req_row_end;
   assign q_data.row_length   = len_v;
   assign q_data.overflow     = (len_v > HDR_LIMIT);

   // Run state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff  <= KIND_ONES;
         count_ff <= '0;
         pay_ff   <= '0;
      end else if (accept) begin
         kind_ff  <= kind_in;
         count_ff <= count_in;
         pay_ff   <= pay_in;
      end
   end

endmodule

// ===== hdl/bre_queue.sv =====
// ----------------------------------------------------------------------------
// Bilevel byte run-length encoder: packet queue
// A short first-in first-out queue in flip-flops that decouples the front
// part from the back part.
// ----------------------------------------------------------------------------
module bre_queue #(
   parameter int DEPTH = bre_pkg::QUEUE_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  bre_pkg::pkt_type push_data,
   output logic             full,
   input  logic             pop,
   output bre_pkg::pkt_type head_data,
   output logic             empty
);
   import bre_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   pkt_type          entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic             do_push, do_pop;

   assign full      = (fill_ff == CNT_W'(DEPTH));
   assign empty     = (fill_ff == '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;
   assign head_data = entry_ff[rd_ptr_ff];

   // Pointer and fill level updates, with wrap at the queue depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hdl/bre_back.sv =====
// ----------------------------------------------------------------------------
// Bilevel byte run-length encoder: back part
// Takes packets from the queue and sends their code words out one word
// per cycle while the port is not stalled, through a registered result port.
// ----------------------------------------------------------------------------
module bre_back (
   input  logic                       clock,
   input  logic                       reset,
   input  bre_pkg::pkt_type           head_data,
   input  logic                       q_empty,
   output logic                       q_pop,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [bre_pkg::CODE_W-1:0] rsp_code_byte,
   output logic                       rsp_item_last,
   output logic                       rsp_row_done,
   output logic [bre_pkg::LEN_W-1:0]  rsp_row_length,
   output logic                       rsp_length_overflow
);
   import bre_pkg::*;

   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic              valid_ff, valid_in;
   logic [CODE_W-1:0] code_ff;
   logic              last_ff, done_ff, ovf_ff;
   logic [LEN_W-1:0]  len_ff;
   logic              load, fin, done;

   // The output register loads from a non-empty queue when it is empty or being drained.
   assign load = !q_empty && (!valid_ff || !rsp_stall);
   assign fin  = (slot_ff == head_data.last_idx);
   assign done = fin && head_data.row_end;

   assign q_pop = load && fin;

   always_comb begin
      slot_in  = slot_ff;
      valid_in = valid_ff;
      if (load) begin
         slot_in  = fin ? '0 : slot_ff + 1'b1;
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         slot_ff  <= slot_in;
         valid_ff <= valid_in;
      end
   end

   // Result word register.
   always_ff @(posedge clock) begin
      if (load) begin
         code_ff <= head_data.code[slot_ff];
         last_ff <= fin;
         done_ff <= done;
         len_ff  <= done ? head_data.row_length : '0;
         ovf_ff  <= done && head_data.overflow;
      end
   end

   assign rsp_valid           = valid_ff;
   assign rsp_code_byte       = code_ff;
   assign rsp_item_last       = last_ff;
   assign rsp_row_done        = done_ff;
   assign rsp_row_length      = len_ff;
   assign rsp_length_overflow = ovf_ff;

endmodule

// ===== hdl/bilevel_byte_rle_encoder_top.sv =====
// The first code word of a byte passes through the packet queue and then the result register.
// Throughput: one pixel byte per cycle while bytes cause at most one code word and the
// result port is not stalled; the result port sends one word per cycle unless stalled.
// The packet queue (QUEUE_DEPTH entries) absorbs bursts before req_stall rises.
// Reset (synchronous): empty ones run, zero run and payload counts, queue and output
// register empty.
// ----------------------------------------------------------------------------
// Bilevel byte run-length encoder: top level
// Front part classifies pixel bytes, a queue holds the packets, and the
// back part sends out the code words.
// ----------------------------------------------------------------------------
module bilevel_byte_rle_encoder_top #(
   parameter int QUEUE_DEPTH = bre_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [bre_pkg::CODE_W-1:0] req_pixel_byte,
   input  logic                       req_row_end,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [bre_pkg::CODE_W-1:0] rsp_code_byte,
   output logic                       rsp_item_last,
   output logic                       rsp_row_done,
   output logic [bre_pkg::LEN_W-1:0]  rsp_row_length,
   output logic                       rsp_length_overflow
);
   import bre_pkg::*;

   pkt_type push_data, head_data;
   logic    push, full, pop, empty;

   // Front part: run tracking and code word generation.
   bre_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_pixel_byte (req_pixel_byte),
      .req_row_end    (req_row_end),
      .q_full         (full),
      .q_push         (push),
      .q_data         (push_data)
   );

   // Packet queue between the two parts.
   bre_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .head_data (head_data),
      .empty     (empty)
   );

   // Back part: one code word per cycle to the result port while it is not stalled.
   bre_back u_back (
      .clock               (clock),
      .reset               (reset),
      .head_data           (head_data),
      .q_empty             (empty),
      .q_pop               (pop),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_code_byte       (rsp_code_byte),
      .rsp_item_last       (rsp_item_last),
      .rsp_row_done        (rsp_row_done),
      .rsp_row_length      (rsp_row_length),
      .rsp_length_overflow (rsp_length_overflow)
   );

endmodule

// ===== hdl/bre_checker.sv =====
// ----------------------------------------------------------------------------
// Bilevel byte run-length encoder: port checker
// Watches the top level's ports for consistent row reporting and a held
// result word under stall.
// ----------------------------------------------------------------------------
module bre_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input logic [bre_pkg::CODE_W-1:0] rsp_code_byte,
   input logic                       rsp_item_last,
   input logic                       rsp_row_done,
   input logic [bre_pkg::LEN_W-1:0]  rsp_row_length,
   input logic                       rsp_length_overflow
);
   import bre_pkg::*;

   // The row's closing word is always the last word of its pixel byte.
   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_row_done |-> rsp_item_last)
      else $error("row_done without item_last");

   // Row information is zero on every word that does not close a row.
   a_len_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_row_done |-> rsp_row_length == '0 && !rsp_length_overflow)
      else $error("row length shown outside row end");

   // The overflow flag follows the reported row length.
   a_overflow: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_row_done |-> rsp_length_overflow == (rsp_row_length > HDR_LIMIT))
      else $error("length_overflow disagrees with row_length");

   // A stalled result word stays on the port unchanged.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_code_byte)
         && $stable(rsp_item_last) && $stable(rsp_row_done))
      else $error("stalled result word changed");

endmodule

bind bilevel_byte_rle_encoder_top bre_checker u_bre_checker (.*);

// ===== verif/bilevel_byte_rle_encoder_top_test.sv =====
// ----------------------------------------------------------------------------
// Bilevel byte run-length encoder: self-checking test
// Pixel words are fed through the valid/stall request port; each code word
// on the response port is checked against typed table codes or a predictor
// kept in this file. A short table of directed words comes first, then random
// rows of runs and literals. Both sides idle at random but in the last phase.
// ----------------------------------------------------------------------------
module bilevel_byte_rle_encoder_top_test;
   import bre_pkg::*;

   localparam int CYCLE_LIMIT = 20000;
   localparam int N_DIRECTED  = 19;

   // Run state of the predictor.
   typedef enum logic [1:0] {
      KIND_LITERAL = 2'd0,
      KIND_ONES    = 2'd1,
      KIND_ZEROS   = 2'd2
   } run_kind_type;

   // One code word as seen on the response port.
   typedef struct packed {
      logic [CODE_W-1:0] code;
      logic              item_last;
      logic              row_done;
      logic [LEN_W-1:0]  row_length;
      logic              overflow;
   } code_word_type;

   // One directed pixel word; typed rows carry their code words, first in the top byte.
   typedef struct packed {
      logic [CODE_W-1:0] pixel;
      logic              row_end;
      logic              typed;
      logic [2:0]        n_typed;
      logic [31:0]       typed_codes;
      logic [LEN_W-1:0]  typed_len;
   } stim_row_type;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic [CODE_W-1:0] req_pixel_byte;
   logic              req_row_end;
   logic              rsp_valid;
   logic              rsp_stall;
   logic [CODE_W-1:0] rsp_code_byte;
   logic              rsp_item_last;
   logic              rsp_row_done;
   logic [LEN_W-1:0]  rsp_row_length;
   logic              rsp_length_overflow;

   // Predictor state and the code words still to arrive.
   run_kind_type      pred_kind;
   logic [CODE_W-1:0] pred_count;
   logic [LEN_W-1:0]  pred_payload;
   logic [CODE_W-1:0] step_codes[$];
   code_word_type     step_words[$];
   code_word_type     codes_due[$];

   int           idle_phase;
   int           mismatch_count;
   int           cycle_count;
   stim_row_type directed_rows [N_DIRECTED];

   bilevel_byte_rle_encoder_top dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_pixel_byte      (req_pixel_byte),
      .req_row_end         (req_row_end),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_code_byte       (rsp_code_byte),
      .rsp_item_last       (rsp_item_last),
      .rsp_row_done        (rsp_row_done),
      .rsp_row_length      (rsp_row_length),
      .rsp_length_overflow (rsp_length_overflow)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // Emit one code word; the payload count stops at its largest value.
   function automatic void put_code(logic [CODE_W-1:0] b);
      step_codes.push_back(b);
      if (pred_payload != LEN_MAX) pred_payload++;
   endfunction

   // Flush the open run as marker and count; a literal state leaves nothing open.
   function automatic void close_run();
      case (pred_kind)
         KIND_ZEROS: begin
            put_code(MARK_ZEROS);
            put_code(pred_count);
         end
         KIND_ONES: begin
            put_code(MARK_ONES);
            put_code(pred_count);
         end
         default: ;
      endcase
   endfunction

   // Extend a run of the given kind, splitting it once the count is full.
   function automatic void extend_run(run_kind_type kind, logic [CODE_W-1:0] marker);
      if (pred_kind == kind) begin
         if (pred_count == COUNT_MAX) begin
            put_code(marker);
            put_code(COUNT_MAX);
            pred_count = 8'd1;
         end else begin
            pred_count++;
         end
      end else begin
         close_run();
         pred_count = 8'd1;
      end
      pred_kind = kind;
   endfunction

   // Work out the code words that one pixel word causes, into step_words.
   function automatic void predict_codes(logic [CODE_W-1:0] pixel, logic row_end);
      logic [LEN_W-1:0] len;
      code_word_type    w;
      len = '0;
      step_codes.delete();
      step_words.delete();
      if (pixel == MARK_ZEROS) begin
         extend_run(KIND_ZEROS, MARK_ZEROS);
      end else if (pixel == MARK_ONES) begin
         extend_run(KIND_ONES, MARK_ONES);
      end else begin
         close_run();
         put_code(pixel);
         pred_count = '0;
         pred_kind  = KIND_LITERAL;
      end
      // Row end flushes the open run and starts the next row in an empty ones run.
      if (row_end) begin
         close_run();
         len          = pred_payload;
         pred_kind    = KIND_ONES;
         pred_count   = '0;
         pred_payload = '0;
      end
      foreach (step_codes[k]) begin
         w.code       = step_codes[k];
         w.item_last  = (k == step_codes.size() - 1);
         w.row_done   = w.item_last && row_end;
         w.row_length = w.row_done ? len : '0;
         w.overflow   = w.row_done && (len > HDR_LIMIT);
         step_words.push_back(w);
      end
   endfunction

   // Hand one pixel word over, after a random gap while idling, and update the predictor.
   task automatic send_word(input logic [CODE_W-1:0] pixel, input logic row_end);
      int gap_pct;
      gap_pct = (idle_phase == 0) ? 16 : (idle_phase == 1) ? 62 : 0;
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_pixel_byte <= pixel;
      req_row_end    <= row_end;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_codes(pixel, row_end);
   endtask

   task automatic feed_byte(input logic [CODE_W-1:0] pixel, input logic row_end);
      send_word(pixel, row_end);
      foreach (step_words[k]) codes_due.push_back(step_words[k]);
   endtask

   // Mostly zeros and ones so that runs form, with literals mixed in.
   function automatic logic [CODE_W-1:0] row_pixel();
      int pick;
      pick = $urandom_range(9);
      if (pick < 4) return MARK_ZEROS;
      if (pick < 7) return MARK_ONES;
      return CODE_W'($urandom);
   endfunction

   // Short well-formed rows, with some loose words that end rows at random.
   task automatic random_rows(input int n_words);
      int sent;
      int len;
      sent = 0;
      while (sent < n_words) begin
         if ($urandom_range(9) < 8) begin
            len = $urandom_range(1, 12);
            for (int i = 0; i < len; i++) feed_byte(row_pixel(), i == len - 1);
            sent += len;
         end else begin
            feed_byte(CODE_W'($urandom), $urandom_range(7) == 0);
            sent++;
         end
      end
   endtask

   // Check each accepted code word against the oldest one due, and stall at random while idling.
   always @(posedge clock) begin : watch_codes
      code_word_type want;
      int            stall_pct;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (codes_due.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("Unexpected code word %02h (last %0d done %0d length %0d ovf %0d)",
                           rsp_code_byte, rsp_item_last, rsp_row_done, rsp_row_length,
                           rsp_length_overflow);
            end else begin
               want = codes_due.pop_front();
               if (rsp_code_byte !== want.code || rsp_item_last !== want.item_last ||
                   rsp_row_done !== want.row_done || rsp_row_length !== want.row_length ||
                   rsp_length_overflow !== want.overflow) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("Mismatch: expected %02h/%0d/%0d/%0d/%0d, got %02h/%0d/%0d/%0d/%0d",
                              want.code, want.item_last, want.row_done, want.row_length,
                              want.overflow, rsp_code_byte, rsp_item_last, rsp_row_done,
                              rsp_row_length, rsp_length_overflow);
               end
            end
         end
         stall_pct = (idle_phase == 0) ? 62 : (idle_phase == 1) ? 16 : 0;
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Stimulus and end of the run.
   initial begin
      code_word_type w;
      stim_row_type  row;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_pixel_byte = '0;
      req_row_end    = 1'b0;
      idle_phase     = 0;
      pred_kind      = KIND_ONES;
      pred_count     = '0;
      pred_payload   = '0;

      // Directed words: typed rows hold the code words that follow at a glance.
      directed_rows = '{
         '{MARK_ZEROS, 1'b0, 1'b1, 3'd2, {MARK_ONES, 8'h00, 16'h0}, 12'd0},
         '{MARK_ZEROS, 1'b0, 1'b1, 3'd0, 32'h0, 12'd0},
         '{8'h5A, 1'b0, 1'b1, 3'd3, {MARK_ZEROS, 8'h02, 8'h5A, 8'h00}, 12'd0},
         '{MARK_ONES, 1'b1, 1'b1, 3'd2, {MARK_ONES, 8'h01, 16'h0}, 12'd7},
         '{MARK_ONES, 1'b0, 1'b1, 3'd0, 32'h0, 12'd0},
         '{MARK_ONES, 1'b1, 1'b1, 3'd2, {MARK_ONES, 8'h02, 16'h0}, 12'd2},
         '{8'h01, 1'b1, 1'b1, 3'd3, {MARK_ONES, 8'h00, 8'h01, 8'h00}, 12'd3},
         '{8'h80, 1'b0, 1'b0, 3'd0, 32'h0, 12'd0},
         '{8'h7F, 1'b0, 1'b0, 3'd0, 32'h0, 12'd0},
         '{MARK_ZEROS, 1'b0, 1'b0, 3'd0, 32'h0, 12'd0},
         '{8'hFE, 1'b0, 1'b0, 3'd0, 32'h0, 12'd0},
         '{MARK_ZEROS, 1'b1, 1'b0, 3'd0, 32'h0, 12'd0},
         '{MARK_ZEROS, 1'b1, 1'b1, 3'd4, {MARK_ONES, 8'h00, MARK_ZEROS, 8'h01}, 12'd4},
         '{8'h55, 1'b0, 1'b0, 3'd0, 32'h0, 12'd0},
         '{8'hAA, 1'b0, 1'b0, 3'd0, 32'h0, 12'd0},
         '{MARK_ONES, 1'b0, 1'b0, 3'd0, 32'h0, 12'd0},
         '{MARK_ONES, 1'b0, 1'b0, 3'd0, 32'h0, 12'd0},
         '{MARK_ZEROS, 1'b0, 1'b0, 3'd0, 32'h0, 12'd0},
         '{MARK_ZEROS, 1'b1, 1'b0, 3'd0, 32'h0, 12'd0}
      };

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         send_word(row.pixel, row.row_end);
         if (row.typed) begin
            for (int k = 0; k < row.n_typed; k++) begin
               w.code       = row.typed_codes[31 - 8 * k -: 8];
               w.item_last  = (k == row.n_typed - 1);
               w.row_done   = w.item_last && row.row_end;
               w.row_length = w.row_done ? row.typed_len : '0;
               w.overflow   = 1'b0;
               codes_due.push_back(w);
            end
         end else begin
            foreach (step_words[k]) codes_due.push_back(step_words[k]);
         end
      end

      // Random rows under each idling pattern.
      random_rows(55);
      idle_phase = 1;
      random_rows(55);
      idle_phase = 2;
      random_rows(40);

      req_valid <= 1'b0;
      while (codes_due.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/bre_pkg.sv
hdl/bre_front.sv
hdl/bre_queue.sv
hdl/bre_back.sv
hdl/bilevel_byte_rle_encoder_top.sv
hdl/bre_checker.sv
verif/bilevel_byte_rle_encoder_top_test.sv
